// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the modules that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_NOW(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ppt_pkg.sv =====
`timescale 1ns / 1ps

package ppt_pkg;

   // Item modes.
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // Configuration register indexes and port widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_CAP = 2'd2;

   localparam int PLANE_COUNT_W = 7;
   localparam int DIST_W        = 31;
   localparam logic [DIST_W-1:0] DISTANCE_CAP_RESET = 31'd655360;

   // One request beat.
   typedef struct packed {
      logic              mode;
      logic [5:0]        plane_index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
   } req_payload_type;

   // One response beat.
   typedef struct packed {
      logic              inside_res;
      logic [DIST_W-1:0] min_distance;
   } rsp_payload_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_ACC,
      S_CMP,
      S_SAT,
      S_DONE
   } state_type;

   // Vector component fed to the multiplier.
   typedef enum logic [1:0] {
      COMP_X,
      COMP_Y,
      COMP_Z
   } comp_type;

   // Controls for the shared multiply-accumulate unit.
   typedef struct packed {
      logic     init;      // load the accumulator
      logic     init_off;  // load it with the negated plane offset instead of zero
      logic     mul_en;    // form one product this cycle
      logic     use_row;   // take the normal from the table row, not the request
      comp_type sel;
   } mac_ctl_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic        req_ready;
      logic        mem_rd;
      logic        mem_wr;
      logic        eval_start;
      logic        eval_en;
      logic        rsp_load;
      mac_ctl_type mac;
   } seq_ctl_type;

endpackage

// ===== sv/ppt_req_if.sv =====
`timescale 1ns / 1ps

interface ppt_req_if import ppt_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ppt_rsp_if.sv =====
`timescale 1ns / 1ps

interface ppt_rsp_if import ppt_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ppt_plane_mem.sv =====
`timescale 1ns / 1ps

module ppt_plane_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int WIDTH = 128
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Plane rows are written whole.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/ppt_mac.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppt_mac import ppt_pkg::*; #(
   parameter int CW = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mac_ctl_type                        ctl,
   input  logic signed [CW-1:0]               pt_x,
   input  logic signed [CW-1:0]               pt_y,
   input  logic signed [CW-1:0]               pt_z,
   input  logic signed [CW-1:0]               item_nx,
   input  logic signed [CW-1:0]               item_ny,
   input  logic signed [CW-1:0]               item_nz,
   input  logic signed [CW-1:0]               row_nx,
   input  logic signed [CW-1:0]               row_ny,
   input  logic signed [CW-1:0]               row_nz,
   input  logic signed [CW-1:0]               row_off,
   output logic signed [2*CW-16+2:0]          acc
);

   localparam int PW = 2 * CW;
   localparam int QW = PW - 16;
   localparam int DW = QW + 3;

   logic signed [CW-1:0] op_n;
   logic signed [CW-1:0] op_p;
   logic signed [PW-1:0] prod_full;
   logic signed [QW-1:0] prod_ff;
   logic signed [QW-1:0] prod_in;
   logic                 prod_valid_ff;
   logic signed [DW-1:0] acc_ff;
   logic signed [DW-1:0] acc_in;

   // Pick one normal component and the matching point component.
   always_comb begin
      case (ctl.sel)
         COMP_X: begin
            op_n = ctl.use_row ? row_nx : item_nx;
            op_p = pt_x;
         end
         COMP_Y: begin
            op_n = ctl.use_row ? row_ny : item_ny;
            op_p = pt_y;
         end
         COMP_Z: begin
            op_n = ctl.use_row ? row_nz : item_nz;
            op_p = pt_z;
         end
         default: begin
            op_n = '0;
            op_p = '0;
         end
      endcase
   end

   // Exact product, then an arithmetic shift by 16 rounds toward minus infinity.
   assign prod_full = op_n * op_p;
   assign prod_in   = prod_full[PW-1:16];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctl.mul_en;
      end
   end

   // Accumulator starts at minus the offset (query) or zero (plane write).
   always_comb begin
      acc_in = acc_ff;
      if (ctl.init) begin
         if (ctl.init_off) begin
            acc_in = -{{(DW-CW){row_off[CW-1]}}, row_off};
         end else begin
            acc_in = '0;
         end
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + {{(DW-QW){prod_ff[QW-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

   `ASSERT_DIS(a_init_no_pending, clock, reset, ctl.init |-> !prod_valid_ff, "accumulator loaded while a product is pending")

endmodule

// ===== sv/ppt_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppt_ctrl import ppt_pkg::*; #(
   parameter int AW = 6,
   parameter int IW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_fire,
   input  logic          req_mode,
   input  logic          slot_ok,
   input  logic [IW-1:0] count_eff,
   input  logic          out_free,
   output seq_ctl_type   ctl,
   output logic [AW-1:0] rd_addr
);

   state_type     state_ff;
   state_type     state_in;
   logic          mode_ff;
   logic          mode_in;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] idx_in;
   logic [IW-1:0] count_ff;
   logic [IW-1:0] count_in;
   logic          is_query;

   assign is_query = (mode_ff == MODE_QUERY);

   // Next state, plane index and latched item details.
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               idx_in   = '0;
               count_in = count_eff;
               if (req_mode == MODE_WRITE) begin
                  state_in = slot_ok ? S_MUL0 : S_IDLE;
               end else begin
                  state_in = (count_eff == '0) ? S_DONE : S_READ;
               end
            end
         end
         S_READ: state_in = S_MUL0;
         S_MUL0: state_in = S_MUL1;
         S_MUL1: state_in = S_MUL2;
         S_MUL2: begin
            state_in = S_ACC;
            if (is_query) begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end
         S_ACC: state_in = is_query ? S_CMP : S_SAT;
         S_CMP: state_in = (idx_ff == count_ff) ? S_DONE : S_MUL0;
         S_SAT: state_in = S_IDLE;
         S_DONE: state_in = out_free ? S_IDLE : S_DONE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_WRITE;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
   end

   // Datapath controls for each state.
   always_comb begin
      ctl = '0;
      ctl.mac.sel = COMP_X;
      unique case (state_ff)
         S_IDLE: begin
            ctl.req_ready  = 1'b1;
            ctl.eval_start = req_fire && (req_mode == MODE_QUERY);
         end
         S_READ: ctl.mem_rd = 1'b1;
         S_MUL0: begin
            ctl.mac.init     = 1'b1;
            ctl.mac.init_off = is_query;
            ctl.mac.mul_en   = 1'b1;
            ctl.mac.use_row  = is_query;
            ctl.mac.sel      = COMP_X;
         end
         S_MUL1: begin
            ctl.mac.mul_en  = 1'b1;
            ctl.mac.use_row = is_query;
            ctl.mac.sel     = COMP_Y;
         end
         S_MUL2: begin
            ctl.mac.mul_en  = 1'b1;
            ctl.mac.use_row = is_query;
            ctl.mac.sel     = COMP_Z;
         end
         S_ACC: ctl.mem_rd = is_query;
         S_CMP: ctl.eval_en = 1'b1;
         S_SAT: ctl.mem_wr = 1'b1;
         S_DONE: ctl.rsp_load = out_free;
         default: ;
      endcase
   end

   // The next row is fetched as soon as the index has advanced.
   assign rd_addr = idx_ff[AW-1:0];

   `ASSERT_DIS(a_mem_port_excl, clock, reset, !(ctl.mem_rd && ctl.mem_wr), "table read and write in one cycle")
   `ASSERT_DIS(a_idx_in_range, clock, reset, (state_ff != S_IDLE) |-> (idx_ff <= count_ff), "plane index ran past the plane count")
   `ASSERT_DIS(a_done_all_planes, clock, reset, (state_ff == S_DONE) |-> (idx_ff == count_ff), "query finished with planes left")

endmodule

// ===== sv/point_in_polytope_test_top.sv =====
// Plane write: the offset is formed in S_MUL0 to S_MUL2 and S_ACC and written in S_SAT;
// a write with an out-of-range slot is dropped. A query reads each plane row; the shared
// multiplier forms three products per plane, then one accumulate and one compare follow.
// The beat waits in S_DONE for a free response register; items are taken only in S_IDLE.
// Reset (synchronous, active high) clears the sequencer, the response valid and the CSRs;
// the plane table is not cleared and holds nothing valid until written.
`timescale 1ns / 1ps

module point_in_polytope_test_top import ppt_pkg::*; #(
   parameter int MAX_PLANES = 64,
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   ppt_req_if.sink               req_chan,
   ppt_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int DW = 2 * CW - 16 + 3;
   localparam int EW = ((DW > 32) ? DW : 32) + 1;
   localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int IW = $clog2(MAX_PLANES + 1);
   localparam logic signed [DW-1:0] SAT_HI = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_LO = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};

   seq_ctl_type           seq;
   logic                  req_fire;
   logic                  slot_ok;
   logic [IW-1:0]         count_eff;
   logic                  out_free;
   logic [AW-1:0]         rd_addr;

   logic [PLANE_COUNT_W-1:0] plane_count_ff;
   logic [DIST_W-1:0]        epsilon_ff;
   logic [DIST_W-1:0]        distance_cap_ff;

   logic signed [CW-1:0]  px_ff, py_ff, pz_ff;
   logic signed [CW-1:0]  nx_ff, ny_ff, nz_ff;
   logic [AW-1:0]         slot_ff;

   logic [4*CW-1:0]       row;
   logic [4*CW-1:0]       wr_row;
   logic signed [DW-1:0]  acc;
   logic signed [CW-1:0]  off_sat;

   logic signed [EW-1:0]  d_ext;
   logic signed [EW-1:0]  neg_d;
   logic signed [EW-1:0]  eps_ext;
   logic signed [EW-1:0]  best_ext;
   logic signed [EW-1:0]  neg_best;
   logic                  inside_ff;
   logic                  inside_in;
   logic [DIST_W-1:0]     best_ff;
   logic [DIST_W-1:0]     best_in;

   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff  <= '0;
         epsilon_ff      <= '0;
         distance_cap_ff <= DISTANCE_CAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PLANE_COUNT:  plane_count_ff  <= csr_wdata[PLANE_COUNT_W-1:0];
            CSR_EPSILON:      epsilon_ff      <= csr_wdata;
            CSR_DISTANCE_CAP: distance_cap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request handshake and item decode.
   assign req_chan.ready = seq.req_ready;
   assign req_fire       = req_chan.valid && seq.req_ready;
   assign slot_ok        = (32'(req_chan.payload.plane_index) < 32'(MAX_PLANES));
   assign count_eff      = (32'(plane_count_ff) > 32'(MAX_PLANES)) ?
                           IW'(MAX_PLANES) : IW'(plane_count_ff);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Hold the accepted item; coordinates keep their low CW bits as signed values.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff   <= req_chan.payload.x[CW-1:0];
         py_ff   <= req_chan.payload.y[CW-1:0];
         pz_ff   <= req_chan.payload.z[CW-1:0];
         nx_ff   <= req_chan.payload.nx[CW-1:0];
         ny_ff   <= req_chan.payload.ny[CW-1:0];
         nz_ff   <= req_chan.payload.nz[CW-1:0];
         slot_ff <= AW'(req_chan.payload.plane_index);
      end
   end

   ppt_ctrl #(
      .AW (AW),
      .IW (IW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_mode  (req_chan.payload.mode),
      .slot_ok   (slot_ok),
      .count_eff (count_eff),
      .out_free  (out_free),
      .ctl       (seq),
      .rd_addr   (rd_addr)
   );

   ppt_mac #(
      .CW (CW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (seq.mac),
      .pt_x    (px_ff),
      .pt_y    (py_ff),
      .pt_z    (pz_ff),
      .item_nx (nx_ff),
      .item_ny (ny_ff),
      .item_nz (nz_ff),
      .row_nx  (row[4*CW-1:3*CW]),
      .row_ny  (row[3*CW-1:2*CW]),
      .row_nz  (row[2*CW-1:CW]),
      .row_off (row[CW-1:0]),
      .acc     (acc)
   );

   // Plane offset saturated to the coordinate width before it is stored.
   always_comb begin
      if (acc > SAT_HI) begin
         off_sat = SAT_HI[CW-1:0];
      end else if (acc < SAT_LO) begin
         off_sat = SAT_LO[CW-1:0];
      end else begin
         off_sat = acc[CW-1:0];
      end
   end

   assign wr_row = {nx_ff, ny_ff, nz_ff, off_sat};

   ppt_plane_mem #(
      .DEPTH (MAX_PLANES),
      .AW    (AW),
      .WIDTH (4 * CW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (seq.mem_wr),
      .wr_addr (slot_ff),
      .wr_data (wr_row),
      .rd_en   (seq.mem_rd),
      .rd_addr (rd_addr),
      .rd_data (row)
   );

   // Excess check and running minimum; |d| < best is tested as -best < d < best.
   assign d_ext    = {{(EW-DW){acc[DW-1]}}, acc};
   assign neg_d    = -d_ext;
   assign eps_ext  = {{(EW-DIST_W){1'b0}}, epsilon_ff};
   assign best_ext = {{(EW-DIST_W){1'b0}}, best_ff};
   assign neg_best = -best_ext;

   always_comb begin
      inside_in = inside_ff;
      best_in   = best_ff;
      if (seq.eval_start) begin
         inside_in = 1'b1;
         best_in   = distance_cap_ff;
      end else if (seq.eval_en) begin
         if (d_ext > eps_ext) begin
            inside_in = 1'b0;
         end
         if ((d_ext < best_ext) && (d_ext > neg_best)) begin
            best_in = d_ext[EW-1] ? neg_d[DIST_W-1:0] : d_ext[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      inside_ff <= inside_in;
      best_ff   <= best_in;
   end

   // Response register; a finished beat waits here until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq.rsp_load) begin
         rsp_data_ff.inside_res   <= inside_ff;
         rsp_data_ff.min_distance <= best_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
